/* rtl/stis_pkg.sv */
package stis_pkg;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Control handed from one search cell to the next
  typedef struct packed {
    logic valid;
    logic descend;
  } stis_ctl_t;

  // Search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR_A,
    S_DIR_B,
    S_DIR_C,
    S_RUN,
    S_FINISH
  } stis_state_t;

endpackage

/* rtl/stis_cell.sv */
module stis_cell #(
  parameter int AW = 10,
  parameter int CW = 11,
  parameter int KW = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stis_pkg::stis_ctl_t      up_ctl,
  input  logic [CW-1:0]            up_lo,
  input  logic [CW-1:0]            up_hp,
  input  logic signed [KW-1:0]     key,
  input  logic signed [KW-1:0]     rd_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  output stis_pkg::stis_ctl_t      dn_ctl,
  output logic [CW-1:0]            dn_lo,
  output logic [CW-1:0]            dn_hp
);

  // hp holds hi+1, so the interval is live while lo < hp
  logic                live;
  logic [CW:0]         mid_sum;
  logic                busy_r;
  logic                live_r;
  logic                desc_r;
  logic [CW-1:0]       lo_r;
  logic [CW-1:0]       hp_r;
  logic [CW-1:0]       mid_r;
  logic                go_left;
  logic [CW-1:0]       lo_nxt;
  logic [CW-1:0]       hp_nxt;
  stis_pkg::stis_ctl_t dn_ctl_r;
  logic [CW-1:0]       dn_lo_r;
  logic [CW-1:0]       dn_hp_r;

  // Issue the probe read for the incoming interval
  assign live    = up_ctl.valid && (up_lo < up_hp);
  assign mid_sum = {1'b0, up_lo} + {1'b0, up_hp} - (CW + 1)'(1);
  assign rd_en   = live;
  assign rd_addr = mid_sum[AW:1];

  // Hold the interval while the probe read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      live_r <= 1'b0;
    end else begin
      busy_r <= up_ctl.valid;
      live_r <= live;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= up_ctl.descend;
    lo_r   <= up_lo;
    hp_r   <= up_hp;
    mid_r  <= mid_sum[CW:1];
  end

  // Narrow the interval from the probed entry
  always_comb begin
    go_left = desc_r ? (rd_data <= key) : (rd_data >= key);
    lo_nxt  = lo_r;
    hp_nxt  = hp_r;
    if (live_r) begin
      if (go_left) begin
        hp_nxt = mid_r;
      end else begin
        lo_nxt = mid_r + CW'(1);
      end
    end
  end

  // Hand the interval to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_ctl_r <= '0;
    end else begin
      dn_ctl_r.valid   <= busy_r;
      dn_ctl_r.descend <= desc_r;
    end
  end

  always_ff @(posedge clk) begin
    dn_lo_r <= lo_nxt;
    dn_hp_r <= hp_nxt;
  end

  assign dn_ctl = dn_ctl_r;
  assign dn_lo  = dn_lo_r;
  assign dn_hp  = dn_hp_r;

endmodule

/* rtl/sorted_table_interval_search.sv */
// Lower-bound search over a table of signed keys. A write item (opcode 0) stores
// one key in the table memory and gives no result. A search item (opcode 1)
// reads entry 0 and the last entry in use to pick the direction, then walks a
// chain of clog2(TABLE_DEPTH+1) bisection cells, one per level, all sharing the
// single registered read port of the table memory; each level issues its probe
// read, then narrows the interval from the returned entry. The next item is
// taken only after the search has offered its result, so one search finishes
// before the next is accepted. An empty table skips the chain and offers 0. A
// result still waiting in the output register holds the following search in
// its last step until that result transfers. Table entries have no reset value;
// only entries already written may be covered by the table count during a
// search. The table count, written through cfg_wr_data, may be changed only
// while no search is in progress.
module sorted_table_interval_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]      cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_opcode,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        in_entry_index,
  input  logic signed [KEY_WIDTH-1:0]           in_entry_value,
  input  logic signed [KEY_WIDTH-1:0]           in_search_key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      out_interval_index
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int LEVELS = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  stis_pkg::stis_state_t state_r, state_nxt;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          n_r, n_nxt;
  logic [CW-1:0]          n_clamp;
  logic [CW-1:0]          nm1;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic signed [KEY_WIDTH-1:0] first_r, first_nxt;
  logic signed [KEY_WIDTH-1:0] rd_data_r;
  logic signed [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  stis_pkg::stis_ctl_t    start_r, start_nxt;
  logic [CW-1:0]          res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CW-1:0]          out_index_r, out_index_nxt;
  logic                   mem_we;
  logic                   wr_ok;
  logic                   seq_rd_en;
  logic [AW-1:0]          seq_addr;
  logic [AW-1:0]          rd_addr;

  stis_pkg::stis_ctl_t    chain_ctl [LEVELS+1];
  logic [CW-1:0]          chain_lo  [LEVELS+1];
  logic [CW-1:0]          chain_hp  [LEVELS+1];
  logic [LEVELS-1:0]      cell_rd_en;
  logic [AW-1:0]          cell_rd_addr [LEVELS];

  // Clamp the count to the table depth
  assign n_clamp = (cnt_r > DEPTH_C) ? DEPTH_C : cnt_r;
  assign nm1     = n_r - CW'(1);
  assign wr_ok   = CW'(in_entry_index) < DEPTH_C;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  // Sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stis_pkg::S_IDLE;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    key_r       <= key_nxt;
    first_r     <= first_nxt;
    res_r       <= res_nxt;
    out_index_r <= out_index_nxt;
  end

  // Next state and outputs of the sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    start_nxt     = '0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    seq_rd_en     = 1'b0;
    seq_addr      = '0;
    mem_we        = 1'b0;
    in_ready      = 1'b0;
    unique case (state_r)
      stis_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == stis_pkg::OP_WRITE) begin
            mem_we = wr_ok;
          end else begin
            n_nxt   = n_clamp;
            key_nxt = in_search_key;
            if (n_clamp == '0) begin
              res_nxt   = '0;
              state_nxt = stis_pkg::S_FINISH;
            end else begin
              state_nxt = stis_pkg::S_DIR_A;
            end
          end
        end
      end
      stis_pkg::S_DIR_A: begin
        seq_rd_en = 1'b1;
        seq_addr  = '0;
        state_nxt = stis_pkg::S_DIR_B;
      end
      stis_pkg::S_DIR_B: begin
        seq_rd_en = 1'b1;
        seq_addr  = nm1[AW-1:0];
        first_nxt = rd_data_r;
        state_nxt = stis_pkg::S_DIR_C;
      end
      stis_pkg::S_DIR_C: begin
        start_nxt.valid   = 1'b1;
        start_nxt.descend = first_r > rd_data_r;
        state_nxt         = stis_pkg::S_RUN;
      end
      stis_pkg::S_RUN: begin
        if (chain_ctl[LEVELS].valid) begin
          res_nxt   = chain_hp[LEVELS];
          state_nxt = stis_pkg::S_FINISH;
        end
      end
      stis_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_r;
          state_nxt     = stis_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = stis_pkg::S_IDLE;
      end
    endcase
  end

  // Merge read requests; at most one is active in a cycle
  always_comb begin
    rd_addr = seq_rd_en ? seq_addr : '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (cell_rd_en[i]) begin
        rd_addr = rd_addr | cell_rd_addr[i];
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_entry_index] <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Bisection chain, one cell per level
  assign chain_ctl[0] = start_r;
  assign chain_lo[0]  = '0;
  assign chain_hp[0]  = n_r;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    stis_cell #(
      .AW (AW),
      .CW (CW),
      .KW (KEY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_ctl  (chain_ctl[g]),
      .up_lo   (chain_lo[g]),
      .up_hp   (chain_hp[g]),
      .key     (key_r),
      .rd_data (rd_data_r),
      .rd_en   (cell_rd_en[g]),
      .rd_addr (cell_rd_addr[g]),
      .dn_ctl  (chain_ctl[g+1]),
      .dn_lo   (chain_lo[g+1]),
      .dn_hp   (chain_hp[g+1])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_interval_index = out_index_r;

  // Only one cell probes the table at a time
  a_one_cell_read: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_rd_en))
    else $error("two search cells read the table in one cycle");

  // Direction reads never collide with cell reads
  a_seq_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    seq_rd_en |-> (cell_rd_en == '0))
    else $error("direction read overlaps a cell read");

  // The chain finishes only while a search runs
  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl[LEVELS].valid |-> (state_r == stis_pkg::S_RUN))
    else $error("search chain finished outside a search");

  // A result never exceeds the entries in use
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stis_pkg::S_FINISH) |-> (res_r <= n_r))
    else $error("interval index beyond table count");

endmodule

/* verif/interval_index_checker.sv */
module interval_index_checker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] cfg_wr_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   in_entry_index,
  input  logic signed [KEY_WIDTH-1:0]      in_entry_value,
  input  logic signed [KEY_WIDTH-1:0]      in_search_key,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] out_interval_index,
  output int                               mismatch_count,
  output int                               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = $clog2(TABLE_DEPTH+1);

  // Mirror of the block's table and count register
  logic signed [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];
  logic [CW-1:0]               active_count;
  logic [CW-1:0]               pending_index_q [$];
  int                          fail_total = 0;

  // Insertion point of key over the entries in use, same probe order as the block
  function automatic logic [CW-1:0] insertion_point(input logic signed [KEY_WIDTH-1:0] key);
    int   span;
    int   lo;
    int   hi;
    int   mid;
    logic descend;
    logic go_left;
    span = (int'(active_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    if (span == 0) return '0;
    descend = key_table[0] > key_table[span-1];
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (descend) go_left = key_table[mid] <= key;
      else go_left = key_table[mid] >= key;
      if (go_left) hi = mid - 1;
      else lo = mid + 1;
    end
    return CW'(hi + 1);
  endfunction

  always @(posedge clk) begin : watch_channels
    logic [CW-1:0] want;
    if (!rst_n) begin
      active_count = '0;
      pending_index_q.delete();
    end else begin
      if (cfg_wr_en) active_count = cfg_wr_data;

      // Compare each result transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_index_q.size() == 0) begin
          $display("%0t: result with nothing pending: expected none, actual interval_index %0d",
                   $time, out_interval_index);
          fail_total++;
        end else begin
          want = pending_index_q.pop_front();
          if (out_interval_index !== want) begin
            $display("%0t: interval_index mismatch: expected %0d, actual %0d",
                     $time, want, out_interval_index);
            fail_total++;
          end
        end
      end

      // Apply writes to the mirror, predict searches
      if (in_valid && in_ready) begin
        if (in_opcode == stis_pkg::OP_WRITE) begin
          if (int'(in_entry_index) < TABLE_DEPTH) key_table[in_entry_index] = in_entry_value;
        end else begin
          pending_index_q.push_back(insertion_point(in_search_key));
        end
      end
    end
    results_owed   <= pending_index_q.size();
    mismatch_count <= fail_total;
  end

endmodule

/* verif/sorted_table_interval_search_test.sv */
module sorted_table_interval_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int CW          = $clog2(TABLE_DEPTH+1);
  localparam int IW          = $clog2(TABLE_DEPTH);
  localparam int ITEM_TARGET = 1550;
  localparam int SETTLE_PAD  = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int MAX_COUNT   = 2047;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;
  typedef enum int {SHAPE_ASC, SHAPE_DESC, SHAPE_FLAT, SHAPE_RAND} table_shape_e;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [CW-1:0]               cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_opcode = stis_pkg::OP_WRITE;
  logic [IW-1:0]               in_entry_index = '0;
  logic signed [KEY_WIDTH-1:0] in_entry_value = '0;
  logic signed [KEY_WIDTH-1:0] in_search_key = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [CW-1:0]               out_interval_index;

  int mismatch_count;
  int results_owed;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_done     = 0;
  int writes_sent    = 0;
  int searches_sent  = 0;
  int settings_done  = 0;
  int search_span    = 0;
  int idle_cycles    = 0;

  // Keys the stimulus has loaded, used to aim search keys at table contents
  logic signed [KEY_WIDTH-1:0] loaded_keys [TABLE_DEPTH];

  sorted_table_interval_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_search_key     (in_search_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_interval_index(out_interval_index)
  );

  interval_index_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) lookup_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_search_key     (in_search_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_interval_index(out_interval_index),
    .mismatch_count    (mismatch_count),
    .results_owed      (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_idle_pct  = 68;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_idle_pct  = 0;
        recv_stall_pct = 68;
      end
      default: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
    endcase
  endtask

  // Offer one item and hold it until the transfer; valid stays high afterwards
  task automatic send_item(input logic op, input logic [IW-1:0] idx,
                           input logic signed [KEY_WIDTH-1:0] value,
                           input logic signed [KEY_WIDTH-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_entry_value <= value;
    in_search_key  <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == stis_pkg::OP_WRITE) writes_sent++;
    else searches_sent++;
  endtask

  task automatic write_entry(input int idx, input logic signed [KEY_WIDTH-1:0] value);
    loaded_keys[idx] = value;
    send_item(stis_pkg::OP_WRITE, IW'(idx), value, $urandom);
  endtask

  task automatic look_up(input logic signed [KEY_WIDTH-1:0] key);
    send_item(stis_pkg::OP_SEARCH, IW'($urandom), $urandom, key);
  endtask

  // Drain the block, let it settle, then write table_count
  task automatic set_count(input int count);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CW'(count);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    search_span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    settings_done++;
  endtask

  // Search key: mostly a loaded key or a neighbor, sometimes random or an extreme
  function automatic logic signed [KEY_WIDTH-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (search_span == 0 || roll < 2) return $urandom;
    if (roll == 2) return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    return loaded_keys[$urandom_range(0, search_span - 1)] + $urandom_range(0, 2) - 1;
  endfunction

  // Rewrite entries 0..count-1 with a table of the given shape, in shuffled order
  task automatic load_prefix(input int count, input table_shape_e shape);
    logic signed [KEY_WIDTH-1:0] vals [TABLE_DEPTH];
    int     order [TABLE_DEPTH];
    longint step_max;
    longint span;
    longint acc;
    int     j;
    int     tmp;
    case ($urandom_range(0, 3))
      0: step_max = 1;
      1: step_max = 256;
      2: step_max = 64'sd1 << 20;
      default: step_max = (64'sd1 << 31) / count;
    endcase
    span = step_max * count;
    acc = -64'sd2147483648 + (longint'($urandom) % ((64'sd1 << 32) - span));
    for (int i = 0; i < count; i++) begin
      case (shape)
        SHAPE_ASC:  vals[i] = KEY_WIDTH'(acc);
        SHAPE_DESC: vals[count-1-i] = KEY_WIDTH'(acc);
        SHAPE_FLAT: vals[i] = (i == 0) ? KEY_WIDTH'(acc) : vals[0];
        default:    vals[i] = $urandom;
      endcase
      acc += $urandom_range(0, 32'(step_max));
      order[i] = i;
    end
    for (int i = count - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < count; i++) write_entry(order[i], vals[order[i]]);
  endtask

  initial begin : stimulus
    int           phase;
    int           fill;
    int           count;
    int           roll;
    table_shape_e shape;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table right after reset
    set_pace(PACE_FULL);
    look_up(KEY_MIN);
    look_up(KEY_MAX);
    look_up(0);

    // Ascending table spanning both extremes, with a repeated key
    write_entry(0, KEY_MIN);
    write_entry(1, -100);
    write_entry(2, -5);
    write_entry(3, 0);
    write_entry(4, 0);
    write_entry(5, 7);
    write_entry(6, 1000);
    write_entry(7, KEY_MAX);
    set_count(8);
    look_up(KEY_MIN);
    look_up(KEY_MAX);
    look_up(0);
    look_up(1);
    look_up(-6);

    // Single entry in use
    set_count(1);
    look_up(5);

    // Descending table
    write_entry(0, KEY_MAX);
    write_entry(1, 50);
    write_entry(2, -50);
    write_entry(3, KEY_MIN);
    set_count(4);
    look_up(0);
    look_up(KEY_MAX);
    look_up(KEY_MIN);

    // Equal first and last entries over an unsorted middle: taken as ascending
    write_entry(3, KEY_MAX);
    look_up(60);

    // Fill the whole table, then search it full and with an oversized count
    set_pace(PACE_BOTH);
    load_prefix(TABLE_DEPTH, SHAPE_ASC);
    set_count(TABLE_DEPTH);
    set_pace(PACE_FULL);
    holds_asked++;
    repeat (80) look_up(pick_key());
    set_count(MAX_COUNT);
    set_pace(PACE_RECV_STALLS);
    repeat (20) look_up(pick_key());

    // Random phases: reshape a small prefix, pick a count, search with some noise writes
    phase = 0;
    while (writes_sent + searches_sent < ITEM_TARGET) begin
      set_pace(pace_e'(phase % 4));
      fill = $urandom_range(1, 40);
      roll = $urandom_range(0, 19);
      if (roll < 8) shape = SHAPE_ASC;
      else if (roll < 16) shape = SHAPE_DESC;
      else if (roll < 17) shape = SHAPE_FLAT;
      else shape = SHAPE_RAND;
      load_prefix(fill, shape);
      roll = $urandom_range(0, 9);
      if (roll == 0) count = 0;
      else if (roll == 1) count = $urandom_range(fill + 1, MAX_COUNT);
      else count = fill;
      set_count(count);
      repeat ($urandom_range(15, 35)) begin
        if ($urandom_range(0, 9) == 0) write_entry($urandom_range(0, fill - 1), $urandom);
        else look_up(pick_key());
      end
      phase++;
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
    $display("Covered %0d table writes and %0d searches under %0d table_count settings.",
             writes_sent, searches_sent, settings_done);
    $display("Tables ranged from empty to full and oversized, in four pacing modes.");
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
